// ===== hdl/lbb_pkg.sv =====
// ----------------------------------------------------------------------------
// lbb_pkg
// Shared types and codes of the lru block buffer: command and result beats,
// operation codes and error codes.
// ----------------------------------------------------------------------------
package lbb_pkg;

  localparam int ENTRIES    = 16;
  localparam int SLOT_BITS  = $clog2(ENTRIES);
  localparam int FILE_BITS  = 8;
  localparam int BLOCK_BITS = 24;
  localparam int OP_BITS    = 3;
  localparam int ERR_BITS   = 2;
  localparam int CFG_BITS   = 5;

  localparam logic [OP_BITS-1:0] OP_READ   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_PIN    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_WRITE  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_STATUS = 3'd3;
  localparam logic [OP_BITS-1:0] OP_FLUSH  = 3'd4;
  localparam logic [OP_BITS-1:0] OP_DELETE = 3'd5;

  localparam logic [ERR_BITS-1:0] ERR_OK           = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_ALL_PINNED   = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_NOT_BUFFERED = 2'd2;

  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(ENTRIES);

  typedef struct packed {
    logic [OP_BITS-1:0]    op;
    logic [FILE_BITS-1:0]  file_id;
    logic [BLOCK_BITS-1:0] block_number;
  } cmd_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_BITS-1:0]  slot;
    logic                  need_load;
    logic                  out_valid;
    logic [FILE_BITS-1:0]  out_file;
    logic [BLOCK_BITS-1:0] out_block;
    logic                  pinned;
    logic [ERR_BITS-1:0]   error;
    logic                  last;
  } result_t;

endpackage

// ===== hdl/lru_block_buffer_with_pins.sv =====
// ----------------------------------------------------------------------------
// lru_block_buffer_with_pins
// Fully associative tag store of buffered blocks with lru order and pin
// marks. One tag compare unit walks the slots one per cycle under a small
// sequencer; results leave through a one-beat holding register.
// ----------------------------------------------------------------------------
//  channel   handshake              payload     notes
//  command   start & !busy          cmd         op, file_id, block_number
//  result    result_valid (strobe)  result      one cycle per beat, no stall
//  config    cfg_valid & cfg_ready  cfg_data    entries_in_use, ready always
//
//  read, pin, status, write back: a scan of every slot, then one result beat.
//  flush: a walk over the slots in rank order, beats spread over that walk.
//  delete file: a full scan per emitted entry, then a final empty scan.
//  the slot walk through the single tag compare paces each of these.
//  synchronous reset clears valid bits, pin marks and sets ranks to slot order.
//  results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module lru_block_buffer_with_pins
  import lbb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  cmd_t                cmd,
  output logic                result_valid,
  output result_t             result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_BITS-1:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DONE  = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state;

  logic [FILE_BITS-1:0]  tag_file  [ENTRIES];
  logic [BLOCK_BITS-1:0] tag_block [ENTRIES];
  logic [ENTRIES-1:0]    valid;
  logic [ENTRIES-1:0]    pin;
  logic [SLOT_BITS-1:0]  rank      [ENTRIES];
  logic [CFG_BITS-1:0]   entries_in_use;

  cmd_t                  cmd_q;
  logic [SLOT_BITS-1:0]  idx;

  logic                  hit_found;
  logic [SLOT_BITS-1:0]  hit_slot;
  logic                  free_found;
  logic [SLOT_BITS-1:0]  free_slot;
  logic                  vict_found;
  logic [SLOT_BITS-1:0]  vict_slot;
  logic [SLOT_BITS-1:0]  vict_rank;
  logic [FILE_BITS-1:0]  vict_file;
  logic [BLOCK_BITS-1:0] vict_block;
  logic                  min_found;
  logic [SLOT_BITS-1:0]  min_slot;
  logic [BLOCK_BITS-1:0] min_block;

  result_t               pend;
  logic                  pend_valid;

  logic [CFG_BITS-1:0]   lim;
  logic                  in_lim;
  logic [SLOT_BITS-1:0]  flush_slot;
  logic [SLOT_BITS-1:0]  rd_addr;
  logic [FILE_BITS-1:0]  rd_file;
  logic [BLOCK_BITS-1:0] rd_block;
  logic                  file_eq;
  logic                  match;
  logic                  smaller;
  logic                  new_min;
  logic                  new_vict;
  logic [SLOT_BITS-1:0]  recent_slot;
  logic                  recent_en;
  logic [SLOT_BITS-1:0]  fill_slot;
  logic                  fill_en;
  logic                  fill_evict;
  result_t               done_res;
  result_t               zero_res;
  result_t               walk_res;
  result_t               del_res;
  result_t               fin_res;
  result_t               result_next;
  logic                  result_valid_next;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (entries_in_use == '0) begin
      lim = CFG_BITS'(1);
    end else if (entries_in_use > CFG_BITS'(ENTRIES)) begin
      lim = CFG_BITS'(ENTRIES);
    end else begin
      lim = entries_in_use;
    end
  end

  assign in_lim = (CFG_BITS'(idx) < lim);

  // slot holding rank idx during the flush walk
  always_comb begin
    flush_slot = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (rank[k] == idx) begin
        flush_slot = SLOT_BITS'(k);
      end
    end
  end

  // single tag read port and the shared compare unit
  assign rd_addr  = (state == ST_FLUSH) ? flush_slot : idx;
  assign rd_file  = tag_file[rd_addr];
  assign rd_block = tag_block[rd_addr];
  assign file_eq  = valid[idx] && (rd_file == cmd_q.file_id);
  assign match    = file_eq && (rd_block == cmd_q.block_number);
  assign smaller  = (rd_block < min_block);
  assign new_min  = file_eq && (!min_found || smaller);
  assign new_vict = in_lim && !pin[idx] && (!vict_found || rank[idx] < vict_rank);

  assign zero_res = '0;

  always_comb begin
    walk_res           = '0;
    walk_res.slot      = flush_slot;
    walk_res.out_valid = 1'b1;
    walk_res.out_file  = rd_file;
    walk_res.out_block = rd_block;
    walk_res.pinned    = pin[flush_slot];
  end

  always_comb begin
    del_res           = zero_res;
    del_res.slot      = min_slot;
    del_res.out_valid = 1'b1;
    del_res.out_file  = cmd_q.file_id;
    del_res.out_block = min_block;
    del_res.pinned    = pin[min_slot];
  end

  // final beat of a walk, or the empty beat
  always_comb begin
    fin_res      = pend_valid ? pend : zero_res;
    fin_res.last = 1'b1;
  end

  // single-result outcome of read, pin, status and write back
  always_comb begin
    done_res      = '0;
    done_res.last = 1'b1;
    recent_en     = 1'b0;
    recent_slot   = hit_slot;
    fill_en       = 1'b0;
    fill_evict    = 1'b0;
    fill_slot     = free_slot;
    case (cmd_q.op)
      OP_READ: begin
        if (hit_found) begin
          done_res.hit    = 1'b1;
          done_res.slot   = hit_slot;
          done_res.pinned = pin[hit_slot];
          recent_en       = 1'b1;
        end else if (free_found || vict_found) begin
          fill_en    = 1'b1;
          fill_evict = !free_found;
          fill_slot  = free_found ? free_slot : vict_slot;
          recent_en   = 1'b1;
          recent_slot = fill_slot;
          done_res.slot      = fill_slot;
          done_res.need_load = 1'b1;
          if (!free_found) begin
            done_res.out_valid = 1'b1;
            done_res.out_file  = vict_file;
            done_res.out_block = vict_block;
          end
        end else begin
          done_res.error = ERR_ALL_PINNED;
        end
      end
      OP_PIN, OP_STATUS: begin
        if (hit_found) begin
          done_res.hit    = 1'b1;
          done_res.slot   = hit_slot;
          done_res.pinned = (cmd_q.op == OP_PIN) ? 1'b1 : pin[hit_slot];
        end else begin
          done_res.error = ERR_NOT_BUFFERED;
        end
      end
      OP_WRITE: begin
        done_res.out_valid = 1'b1;
        done_res.out_file  = cmd_q.file_id;
        done_res.out_block = cmd_q.block_number;
        if (hit_found) begin
          done_res.hit    = 1'b1;
          done_res.slot   = hit_slot;
          done_res.pinned = pin[hit_slot];
        end
      end
      default: begin
        done_res = done_res;
      end
    endcase
  end

  // result beat leaving at the next edge
  always_comb begin
    result_valid_next = 1'b0;
    result_next       = fin_res;
    case (state)
      ST_IDLE: begin
        result_valid_next = start && !(cmd.op inside {OP_READ, OP_PIN, OP_WRITE,
                                                      OP_STATUS, OP_FLUSH, OP_DELETE});
      end
      ST_DONE: begin
        if (cmd_q.op == OP_DELETE) begin
          result_valid_next = min_found && pend_valid;
          result_next       = pend;
        end else begin
          result_valid_next = 1'b1;
          result_next       = done_res;
        end
      end
      ST_FLUSH: begin
        result_valid_next = valid[flush_slot] && pend_valid;
        result_next       = pend;
      end
      ST_FIN: begin
        result_valid_next = 1'b1;
      end
      default: begin
        result_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      valid          <= '0;
      pin            <= '0;
      entries_in_use <= CFG_RESET;
      result_valid   <= 1'b0;
      pend_valid     <= 1'b0;
      idx            <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        rank[j] <= SLOT_BITS'(j);
      end
    end else begin
      result_valid <= result_valid_next;
      if (result_valid_next) begin
        result <= result_next;
      end
      if (cfg_valid && cfg_ready) begin
        entries_in_use <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q      <= cmd;
            idx        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            vict_found <= 1'b0;
            min_found  <= 1'b0;
            pend_valid <= 1'b0;
            if (cmd.op inside {OP_READ, OP_PIN, OP_WRITE, OP_STATUS, OP_DELETE}) begin
              state <= ST_SCAN;
            end else if (cmd.op == OP_FLUSH) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_SCAN: begin
          if (match && !hit_found) begin
            hit_found <= 1'b1;
            hit_slot  <= idx;
          end
          if (in_lim && !valid[idx] && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= idx;
          end
          if (new_vict) begin
            vict_found <= 1'b1;
            vict_slot  <= idx;
            vict_rank  <= rank[idx];
            vict_file  <= rd_file;
            vict_block <= rd_block;
          end
          if (new_min) begin
            min_found <= 1'b1;
            min_slot  <= idx;
            min_block <= rd_block;
          end
          if (idx == SLOT_BITS'(ENTRIES - 1)) begin
            state <= ST_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DONE: begin
          if (cmd_q.op == OP_DELETE) begin
            if (min_found) begin
              pend            <= del_res;
              pend_valid      <= 1'b1;
              valid[min_slot] <= 1'b0;
              pin[min_slot]   <= 1'b0;
              min_found <= 1'b0;
              idx       <= '0;
              state     <= ST_SCAN;
            end else begin
              state <= ST_FIN;
            end
          end else begin
            state <= ST_IDLE;
            if (recent_en) begin
              for (int j = 0; j < ENTRIES; j++) begin
                if (rank[j] > rank[recent_slot]) begin
                  rank[j] <= rank[j] - 1'b1;
                end
              end
              rank[recent_slot] <= SLOT_BITS'(ENTRIES - 1);
            end
            if (fill_en) begin
              tag_file[fill_slot]  <= cmd_q.file_id;
              tag_block[fill_slot] <= cmd_q.block_number;
              valid[fill_slot]     <= 1'b1;
              pin[fill_slot]       <= 1'b0;
            end
            if (cmd_q.op == OP_PIN && hit_found) begin
              pin[hit_slot] <= 1'b1;
            end
            if (cmd_q.op == OP_WRITE && hit_found) begin
              valid[hit_slot] <= 1'b0;
              pin[hit_slot]   <= 1'b0;
            end
          end
        end
        ST_FLUSH: begin
          if (valid[flush_slot]) begin
            pend       <= walk_res;
            pend_valid <= 1'b1;
          end
          if (idx == SLOT_BITS'(ENTRIES - 1)) begin
            state <= ST_FIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_FIN: begin
          if (cmd_q.op == OP_FLUSH) begin
            valid <= '0;
            pin   <= '0;
          end
          pend_valid <= 1'b0;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
